### rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bsc_pkg;

   // Configuration register file layout.
   localparam int CAL_REGS = 6;
   localparam int ADDR_W   = 5;

   typedef enum logic [2:0] {
      REG_CAL_T1_T2 = 3'd0,
      REG_CAL_T3_P1 = 3'd1,
      REG_CAL_P2_P3 = 3'd2,
      REG_CAL_P4_P5 = 3'd3,
      REG_CAL_P6_P7 = 3'd4,
      REG_CAL_P8_P9 = 3'd5
   } bsc_reg_type;

   // Pipeline depth of each part and of the whole datapath.
   localparam int TEMP_STAGES = 4;
   localparam int PRES_STAGES = 6;
   localparam int DIV_STAGES  = 32;
   localparam int DIV_BITS    = 2;
   localparam int POST_STAGES = 7;
   localparam int LATENCY     = TEMP_STAGES + PRES_STAGES + DIV_STAGES + POST_STAGES;

   // Compensation constants.
   localparam logic signed [26:0] FINE_OFFSET    = 27'sd128000;
   localparam logic [20:0]        P_BASE         = 21'd1048576;
   localparam logic [11:0]        P_SCALE        = 12'd3125;
   localparam logic signed [28:0] TEMP_ROUND     = 29'sd128;
   localparam logic signed [28:0] TEMP_SCALE     = 29'sd5;
   localparam int                 DEN_BIAS_SHIFT = 47;
   localparam logic [63:0]        DEN_BIAS       = 64'd1 << DEN_BIAS_SHIFT;
   localparam int                 P4_SHIFT       = 35;
   localparam int                 P5_SHIFT       = 17;
   localparam int                 P2_SHIFT       = 12;
   localparam int                 P7_SHIFT       = 4;

   // Unpacked calibration coefficients.
   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } bsc_cal_type;

   // Temperature stages to pressure front end.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] temp;
      logic [19:0]        adc_p;
      logic signed [25:0] fine;
   } bsc_temp_out_type;

   // Pressure front end to divider: magnitudes and quotient sign.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] temp;
      logic               dz;
      logic               neg;
      logic [63:0]        num;
      logic [31:0]        den;
   } bsc_div_in_type;

   // One divider stage.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] temp;
      logic               dz;
      logic               neg;
      logic [31:0]        rem;
      logic [63:0]        nq;
      logic [31:0]        ad;
   } bsc_div_stage_type;

   // Divider to post-processing.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] temp;
      logic               dz;
      logic               neg;
      logic [63:0]        quo;
   } bsc_div_out_type;

   // Final result transaction.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] temp;
      logic [31:0]        pres;
      logic               pvalid;
   } bsc_result_type;

endpackage

`default_nettype wire

### rtl/baro_sensor_compensation.sv
// Barometric sensor compensation top level: CSR file and datapath pipeline.
// Depends on bsc_pkg and on bsc_csr, bsc_temp, bsc_pres, bsc_div, bsc_post.
//
// The block takes one raw temperature/pressure transaction every clock cycle
// and delivers each result as a one-cycle rsp_valid strobe; the receiver
// cannot hold results off, so results must be captured when strobed. The
// pipeline consists mostly of the divider, 32 stages that each retire two
// quotient bits, plus 4 temperature, 6 pressure and 7 back-end stages. busy
// is high only during reset. Write calibration registers only while no
// transaction is in flight.
`default_nettype none

module baro_sensor_compensation import bsc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [19:0]       req_raw_temperature,
   input  wire logic [19:0]       req_raw_pressure,
   output logic                   rsp_valid,
   output logic signed [15:0]     rsp_temperature_centi,
   output logic [31:0]            rsp_pressure_q24_8,
   output logic                   rsp_pressure_valid,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   bsc_cal_type      cal;
   bsc_temp_out_type temp_out;
   bsc_div_in_type   div_in;
   bsc_div_out_type  div_out;
   bsc_result_type   res;
   logic             accept;

   assign busy   = reset;
   assign accept = start && !busy;

   bsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cal     (cal)
   );

   bsc_temp u_temp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .adc_t    (req_raw_temperature),
      .adc_p    (req_raw_pressure),
      .cal      (cal),
      .result   (temp_out)
   );

   bsc_pres u_pres (
      .clock  (clock),
      .reset  (reset),
      .src    (temp_out),
      .cal    (cal),
      .result (div_in)
   );

   bsc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .src    (div_in),
      .result (div_out)
   );

   bsc_post u_post (
      .clock  (clock),
      .reset  (reset),
      .src    (div_out),
      .cal    (cal),
      .result (res)
   );

   // Result transaction.
   assign rsp_valid             = res.valid;
   assign rsp_temperature_centi = res.temp;
   assign rsp_pressure_q24_8    = res.pres;
   assign rsp_pressure_valid    = res.pvalid;

   // Every accepted transaction comes out as a result strobe at the end of the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result strobe");

   // No result strobe appears without an accepted transaction behind it.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe does not match accepted transaction");

   // A zero divisor always forces pressure to zero.
   a_zero_pres: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pressure_valid |-> rsp_pressure_q24_8 == 32'd0)
      else $error("pressure not zero with divisor flagged zero");

   // With P1 zero the divisor is zero for every transaction.
   a_p1_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cal.p1 == 16'd0) |-> !rsp_pressure_valid)
      else $error("pressure flagged valid although P1 is zero");

endmodule

`default_nettype wire

### rtl/bsc_csr.sv
// Calibration register file behind the APB-style configuration port.
// Depends on bsc_pkg for the register map and the coefficient struct.
`default_nettype none

module bsc_csr import bsc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready,
   output bsc_cal_type            cal
);

   logic [31:0] cal_ff [CAL_REGS];
   logic [2:0]  idx;
   logic        hit;
   logic        wr;

   assign idx    = paddr[4:2];
   assign hit    = (idx < 3'(CAL_REGS));
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;

   // Register writes; addresses beyond the map are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAL_REGS; i++) cal_ff[i] <= 32'd0;
      end else if (wr && hit) begin
         cal_ff[idx] <= pwdata;
      end
   end

   // Read data.
   assign prdata = hit ? cal_ff[idx] : 32'd0;

   // Unpack the coefficients.
   always_comb begin
      cal.t1 = cal_ff[REG_CAL_T1_T2][15:0];
      cal.t2 = $signed(cal_ff[REG_CAL_T1_T2][31:16]);
      cal.t3 = $signed(cal_ff[REG_CAL_T3_P1][15:0]);
      cal.p1 = cal_ff[REG_CAL_T3_P1][31:16];
      cal.p2 = $signed(cal_ff[REG_CAL_P2_P3][15:0]);
      cal.p3 = $signed(cal_ff[REG_CAL_P2_P3][31:16]);
      cal.p4 = $signed(cal_ff[REG_CAL_P4_P5][15:0]);
      cal.p5 = $signed(cal_ff[REG_CAL_P4_P5][31:16]);
      cal.p6 = $signed(cal_ff[REG_CAL_P6_P7][15:0]);
      cal.p7 = $signed(cal_ff[REG_CAL_P6_P7][31:16]);
      cal.p8 = $signed(cal_ff[REG_CAL_P8_P9][15:0]);
      cal.p9 = $signed(cal_ff[REG_CAL_P8_P9][31:16]);
   end

endmodule

`default_nettype wire

### rtl/bsc_temp.sv
// Four-stage temperature compensation: fine temperature and 0.01 degC value.
// Depends on bsc_pkg for the coefficient and stage output structs.
`default_nettype none

module bsc_temp import bsc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic [19:0] adc_t,
   input  wire logic [19:0] adc_p,
   input  wire bsc_cal_type cal,
   output bsc_temp_out_type result
);

   logic signed [18:0] d1;
   logic signed [17:0] d2;
   logic signed [35:0] sq_full;
   logic signed [34:0] a1_in, a1_ff;
   logic [32:0]        sq_in, sq_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [19:0]        p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [23:0] a1s_in, a1s_ff;
   logic signed [37:0] b1_in, b1_ff;
   logic signed [25:0] fine_in, fine_ff, fine4_ff;
   logic signed [28:0] t5;
   logic signed [20:0] tc;
   logic signed [15:0] temp_in, temp_ff;

   // Stage 1: offsets from T1 and the first products.
   assign d1      = $signed({2'b00, adc_t[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
   assign d2      = $signed({2'b00, adc_t[19:4]}) - $signed({2'b00, cal.t1});
   assign a1_in   = d1 * $signed(cal.t2);
   assign sq_full = d2 * d2;
   assign sq_in   = sq_full[32:0];

   // Stage 2: quadratic term times T3.
   assign b1_in  = $signed({1'b0, sq_ff[32:12]}) * $signed(cal.t3);
   assign a1s_in = a1_ff[34:11];

   // Stage 3: fine temperature.
   assign fine_in = {{2{a1s_ff[23]}}, a1s_ff} + {{2{b1_ff[37]}}, b1_ff[37:14]};

   // Stage 4: scale to 0.01 degC and saturate.
   assign t5 = {{3{fine_ff[25]}}, fine_ff} * TEMP_SCALE + TEMP_ROUND;
   assign tc = t5[28:8];
   always_comb begin
      if (tc > 21'sd32767)       temp_in = 16'sh7FFF;
      else if (tc < -21'sd32768) temp_in = -16'sh8000;
      else                       temp_in = tc[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff    <= a1_in;
      sq_ff    <= sq_in;
      p1_ff    <= adc_p;
      a1s_ff   <= a1s_in;
      b1_ff    <= b1_in;
      p2_ff    <= p1_ff;
      fine_ff  <= fine_in;
      p3_ff    <= p2_ff;
      temp_ff  <= temp_in;
      fine4_ff <= fine_ff;
      p4_ff    <= p3_ff;
   end

   assign result.valid = v4_ff;
   assign result.temp  = temp_ff;
   assign result.adc_p = p4_ff;
   assign result.fine  = fine4_ff;

endmodule

`default_nettype wire

### rtl/bsc_pres.sv
// Six-stage pressure front end: offset terms, divisor and scaled numerator.
// Depends on bsc_pkg for coefficients, constants and the stage structs.
`default_nettype none

module bsc_pres import bsc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bsc_temp_out_type src,
   input  wire bsc_cal_type      cal,
   output bsc_div_in_type        result
);

   logic [5:0]         v_ff;
   logic signed [15:0] temp_ff [PRES_STAGES-1];
   logic [19:0]        adcp_ff [3];

   logic signed [26:0] pa;
   logic signed [53:0] aa_in, aa_ff;
   logic signed [42:0] ap5_in, ap5_ff, ap2_in, ap2_ff;
   logic signed [42:0] ap5d_ff, ap2d_ff;
   logic signed [69:0] b6_full, a3_full;
   logic [63:0]        b6_ff, a3_ff;
   logic [63:0]        bsum_in, bsum_ff, asum_in, asum_ff;
   logic [20:0]        pp;
   logic [63:0]        num0_in, num0_ff;
   logic [79:0]        d_full;
   logic [63:0]        dprod_ff;
   logic [75:0]        n_full;
   logic [63:0]        num_ff;
   logic signed [30:0] den_ff;
   logic               dz_ff;
   bsc_div_in_type     out_in, out_ff;

   // Stage 5: offset fine temperature and its products.
   assign pa     = {src.fine[25], src.fine} - FINE_OFFSET;
   assign aa_in  = pa * pa;
   assign ap5_in = pa * $signed(cal.p5);
   assign ap2_in = pa * $signed(cal.p2);

   // Stage 6: square times P6 and P3, wrapping to 64 bits; the linear
   // products are delayed one stage to stay aligned with the square terms.
   assign b6_full = aa_ff * $signed(cal.p6);
   assign a3_full = aa_ff * $signed(cal.p3);

   // Stage 7: sum the offset and divisor terms.
   assign bsum_in = b6_ff + ({{21{ap5d_ff[42]}}, ap5d_ff} << P5_SHIFT)
                  + ({{48{cal.p4[15]}}, cal.p4} << P4_SHIFT);
   assign asum_in = {{8{a3_ff[63]}}, a3_ff[63:8]}
                  + ({{21{ap2d_ff[42]}}, ap2d_ff} << P2_SHIFT) + DEN_BIAS;

   // Stage 8: numerator base and divisor product.
   assign pp      = P_BASE - {1'b0, adcp_ff[2]};
   assign num0_in = {12'd0, pp, 31'd0} - bsum_ff;
   assign d_full  = asum_ff * cal.p1;

   // Stage 9: scaled numerator; stage 10: magnitudes for the divider.
   assign n_full = num0_ff * P_SCALE;
   always_comb begin
      out_in.valid = v_ff[4];
      out_in.temp  = temp_ff[4];
      out_in.dz    = dz_ff;
      out_in.neg   = num_ff[63] ^ den_ff[30];
      out_in.num   = num_ff[63] ? (64'd0 - num_ff) : num_ff;
      out_in.den   = den_ff[30] ? (32'd0 - {den_ff[30], den_ff}) : {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[4:0], src.valid};
      end
   end

   always_ff @(posedge clock) begin
      temp_ff[0] <= src.temp;
      for (int i = 1; i < PRES_STAGES - 1; i++) temp_ff[i] <= temp_ff[i-1];
      adcp_ff[0] <= src.adc_p;
      adcp_ff[1] <= adcp_ff[0];
      adcp_ff[2] <= adcp_ff[1];
      aa_ff      <= aa_in;
      ap5_ff     <= ap5_in;
      ap2_ff     <= ap2_in;
      ap5d_ff    <= ap5_ff;
      ap2d_ff    <= ap2_ff;
      b6_ff      <= b6_full[63:0];
      a3_ff      <= a3_full[63:0];
      bsum_ff    <= bsum_in;
      asum_ff    <= asum_in;
      num0_ff    <= num0_in;
      dprod_ff   <= d_full[63:0];
      num_ff     <= n_full[63:0];
      den_ff     <= $signed(dprod_ff[63:33]);
      dz_ff      <= (dprod_ff[63:33] == 31'd0);
      out_ff     <= out_in;
   end

   always_comb begin
      result       = out_ff;
      result.valid = v_ff[5];
   end

endmodule

`default_nettype wire

### rtl/bsc_div.sv
// Pipelined restoring divider on magnitudes, two quotient bits per stage.
// Depends on bsc_pkg for the stage structs and the stage count.
`default_nettype none

module bsc_div import bsc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bsc_div_in_type src,
   output bsc_div_out_type     result
);

   bsc_div_stage_type stage_ff [DIV_STAGES];
   bsc_div_stage_type stage_in [DIV_STAGES];
   bsc_div_stage_type first;

   // Seed the shift register with the dividend and a zero remainder.
   always_comb begin
      first.valid = src.valid;
      first.temp  = src.temp;
      first.dz    = src.dz;
      first.neg   = src.neg;
      first.rem   = 32'd0;
      first.nq    = src.num;
      first.ad    = src.den;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      bsc_div_stage_type cur;
      logic [32:0]       t;
      logic              qb;

      if (s == 0) begin : g_head
         assign cur = first;
      end else begin : g_body
         assign cur = stage_ff[s-1];
      end

      // Shift in two dividend bits, one at a time, subtracting when the divisor fits.
      always_comb begin
         stage_in[s] = cur;
         t  = 33'd0;
         qb = 1'b0;
         for (int k = 0; k < DIV_BITS; k++) begin
            t = {stage_in[s].rem, stage_in[s].nq[63]};
            if (t >= {1'b0, stage_in[s].ad}) begin
               t  = t - {1'b0, stage_in[s].ad};
               qb = 1'b1;
            end else begin
               qb = 1'b0;
            end
            stage_in[s].rem = t[31:0];
            stage_in[s].nq  = {stage_in[s].nq[62:0], qb};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s] <= '0;
         end else begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign result.valid = stage_ff[DIV_STAGES-1].valid;
   assign result.temp  = stage_ff[DIV_STAGES-1].temp;
   assign result.dz    = stage_ff[DIV_STAGES-1].dz;
   assign result.neg   = stage_ff[DIV_STAGES-1].neg;
   assign result.quo   = stage_ff[DIV_STAGES-1].nq;

endmodule

`default_nettype wire

### rtl/bsc_post.sv
// Seven-stage pressure back end: sign, P7..P9 correction, Q24.8 clamp.
// Depends on bsc_pkg for coefficients and the result struct.
`default_nettype none

module bsc_post import bsc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire bsc_div_out_type src,
   input  wire bsc_cal_type     cal,
   output bsc_result_type       result
);

   logic [6:0]         v_ff;
   logic signed [15:0] temp_ff [POST_STAGES];
   logic               dz_ff   [POST_STAGES];
   logic [63:0]        q_ff    [4];

   logic [63:0] x;
   logic [63:0] sqlo_in, sqlo_ff, cross_full;
   logic [31:0] cross_ff;
   logic [79:0] p8_full, a9_full;
   logic [63:0] p8p_ff, p8s_ff, p8s4_ff, xx_ff, a9p_ff, s_ff, r_ff;
   logic [63:0] s_in, r_in;
   logic [31:0] pres_in, pres_ff;

   // Stage 2 squares the shifted quotient in halves, wrapping to 64 bits.
   assign x          = {{13{q_ff[0][63]}}, q_ff[0][63:13]};
   assign sqlo_in    = x[31:0] * x[31:0];
   assign cross_full = x[63:32] * x[31:0];
   assign p8_full    = $signed(q_ff[0]) * $signed(cal.p8);

   // Stage 4 scales by P9; stages 5 and 6 sum the corrections.
   assign a9_full = $signed(xx_ff) * $signed(cal.p9);
   assign s_in    = q_ff[3] + {{25{a9p_ff[63]}}, a9p_ff[63:25]} + p8s4_ff;
   assign r_in    = {{8{s_ff[63]}}, s_ff[63:8]} + ({{48{cal.p7[15]}}, cal.p7} << P7_SHIFT);

   // Stage 7 clamps to the unsigned 32-bit range and forces zero for a zero divisor.
   always_comb begin
      if (dz_ff[5] || r_ff[63])    pres_in = 32'd0;
      else if (r_ff[63:32] != 0)   pres_in = 32'hFFFF_FFFF;
      else                         pres_in = r_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[5:0], src.valid};
      end
   end

   always_ff @(posedge clock) begin
      temp_ff[0] <= src.temp;
      dz_ff[0]   <= src.dz;
      for (int i = 1; i < POST_STAGES; i++) begin
         temp_ff[i] <= temp_ff[i-1];
         dz_ff[i]   <= dz_ff[i-1];
      end
      q_ff[0]  <= src.neg ? (64'd0 - src.quo) : src.quo;
      q_ff[1]  <= q_ff[0];
      q_ff[2]  <= q_ff[1];
      q_ff[3]  <= q_ff[2];
      sqlo_ff  <= sqlo_in;
      cross_ff <= cross_full[31:0];
      p8p_ff   <= p8_full[63:0];
      xx_ff    <= sqlo_ff + {cross_ff[30:0], 33'd0};
      p8s_ff   <= {{19{p8p_ff[63]}}, p8p_ff[63:19]};
      a9p_ff   <= a9_full[63:0];
      p8s4_ff  <= p8s_ff;
      s_ff     <= s_in;
      r_ff     <= r_in;
      pres_ff  <= pres_in;
   end

   assign result.valid  = v_ff[6];
   assign result.temp   = temp_ff[6];
   assign result.pres   = pres_ff;
   assign result.pvalid = !dz_ff[6];

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for baro_sensor_compensation.
// Depends on bsc_pkg and the RTL of the block. It predicts every result from
// the calibration values it writes and checks each strobed result in order.
`default_nettype none

module tb;
   import bsc_pkg::*;

   // One compensated sample as the block reports it.
   typedef struct {
      logic signed [15:0] temp;
      logic [31:0]        pres;
      logic               pvalid;
   } sample_type;

   // Directed stimulus row: bank 0 runs on reset calibration, bank 1 on a
   // typical sensor calibration. Expected values are typed in where fixed.
   typedef struct {
      int          bank;
      logic [19:0] raw_t;
      logic [19:0] raw_p;
      bit          fixed;
      sample_type  want;
   } row_type;

   localparam int CYCLE_LIMIT = 600000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [19:0]       req_raw_temperature = '0;
   logic [19:0]       req_raw_pressure = '0;
   logic              rsp_valid;
   logic signed [15:0] rsp_temperature_centi;
   logic [31:0]       rsp_pressure_q24_8;
   logic              rsp_pressure_valid;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   logic [31:0] cal_shadow [CAL_REGS];
   sample_type  pending_results [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;

   baro_sensor_compensation u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_temperature(req_raw_temperature), .req_raw_pressure(req_raw_pressure),
      .rsp_valid(rsp_valid), .rsp_temperature_centi(rsp_temperature_centi),
      .rsp_pressure_q24_8(rsp_pressure_q24_8), .rsp_pressure_valid(rsp_pressure_valid),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // Arithmetic helpers on 64-bit two's complement patterns.
   function automatic logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] asr(logic [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
      logic        neg;
      logic [63:0] an;
      logic [63:0] ad;
      logic [63:0] q;
      neg = n[63] ^ d[63];
      an  = n[63] ? 64'd0 - n : n;
      ad  = d[63] ? 64'd0 - d : d;
      q   = an / ad;
      return neg ? 64'd0 - q : q;
   endfunction

   // Temperature first, then the 64-bit pressure path fed by the fine value.
   function automatic sample_type compensate(logic [19:0] rt, logic [19:0] rp);
      logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, fine, tc, num, den, p;
      logic signed [63:0] ts;
      sample_type r;
      adc_t = {44'd0, rt};
      adc_p = {44'd0, rp};
      t1 = {48'd0, cal_shadow[REG_CAL_T1_T2][15:0]};
      t2 = sx16(cal_shadow[REG_CAL_T1_T2][31:16]);
      t3 = sx16(cal_shadow[REG_CAL_T3_P1][15:0]);
      p1 = {48'd0, cal_shadow[REG_CAL_T3_P1][31:16]};
      p2 = sx16(cal_shadow[REG_CAL_P2_P3][15:0]);
      p3 = sx16(cal_shadow[REG_CAL_P2_P3][31:16]);
      p4 = sx16(cal_shadow[REG_CAL_P4_P5][15:0]);
      p5 = sx16(cal_shadow[REG_CAL_P4_P5][31:16]);
      p6 = sx16(cal_shadow[REG_CAL_P6_P7][15:0]);
      p7 = sx16(cal_shadow[REG_CAL_P6_P7][31:16]);
      p8 = sx16(cal_shadow[REG_CAL_P8_P9][15:0]);
      p9 = sx16(cal_shadow[REG_CAL_P8_P9][31:16]);

      a = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      b = (adc_t >> 4) - t1;
      b = asr(asr(b * b, 12) * t3, 14);
      fine = a + b;
      tc = asr(fine * 64'd5 + 64'd128, 8);
      ts = $signed(tc);
      if (ts > 32767) ts = 32767;
      if (ts < -32768) ts = -32768;
      r.temp = ts[15:0];

      a = fine - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = asr(a * a * p3, 8) + ((a * p2) << 12);
      den = asr(((64'd1 << 47) + a) * p1, 33);
      r.pres = '0;
      r.pvalid = 1'b0;
      if (den != 0) begin
         p = 64'd1048576 - adc_p;
         num = ((p << 31) - b) * 64'd3125;
         p = div_trunc(num, den);
         a = asr(p9 * asr(p, 13) * asr(p, 13), 25);
         b = asr(p8 * p, 19);
         p = asr(p + a + b, 8) + (p7 << 4);
         if (p[63]) r.pres = '0;
         else if (p > 64'hFFFF_FFFF) r.pres = 32'hFFFF_FFFF;
         else r.pres = p[31:0];
         r.pvalid = 1'b1;
      end
      return r;
   endfunction

   // Predict on every accepted transaction, check every strobed result.
   always @(posedge clock) begin
      sample_type want;
      if (!reset && start && !busy) begin
         pending_results.push_back(compensate(req_raw_temperature, req_raw_pressure));
      end
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with no transaction outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_temperature_centi !== want.temp) begin
               $error("temperature_centi expected %0d actual %0d", want.temp,
                      rsp_temperature_centi);
               mismatch_count++;
            end
            if (rsp_pressure_q24_8 !== want.pres) begin
               $error("pressure_q24_8 expected %0d actual %0d", want.pres,
                      rsp_pressure_q24_8);
               mismatch_count++;
            end
            if (rsp_pressure_valid !== want.pvalid) begin
               $error("pressure_valid expected %0d actual %0d", want.pvalid,
                      rsp_pressure_valid);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("baro_sensor_compensation test failed");
         $finish;
      end
   end

   // Send one transaction, idling first at the given percentage.
   task automatic send_sample(logic [19:0] rt, logic [19:0] rp, int idle_pct);
      bit ok;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_raw_temperature <= rt;
      req_raw_pressure <= rp;
      do begin
         @(negedge clock);
         ok = !busy;
         @(posedge clock);
      end while (!ok);
   endtask

   // Stop sending and wait until every expected result has arrived.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One register write: setup phase, access phase, then the port returns to idle.
   task automatic csr_write(bsc_reg_type idx, logic [31:0] value);
      bit ok;
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_W'(4 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ok = pready;
         @(posedge clock);
      end while (!ok);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      cal_shadow[idx] = value;
   endtask

   task automatic load_typical();
      csr_write(REG_CAL_T1_T2, {16'd26435, 16'd27504});
      csr_write(REG_CAL_T3_P1, {16'd36477, -16'sd1000});
      csr_write(REG_CAL_P2_P3, {16'd3024, -16'sd10685});
      csr_write(REG_CAL_P4_P5, {16'd140, 16'd2855});
      csr_write(REG_CAL_P6_P7, {16'd15500, -16'sd7});
      csr_write(REG_CAL_P8_P9, {16'd6000, -16'sd14600});
   endtask

   // Typical coefficient plus a small random offset in each half.
   function automatic logic [31:0] jitter(logic [31:0] base);
      logic [15:0] lo;
      logic [15:0] hi;
      lo = base[15:0] + 16'($urandom_range(64)) - 16'd32;
      hi = base[31:16] + 16'($urandom_range(64)) - 16'd32;
      return {hi, lo};
   endfunction

   // Calibration set by kind: typical with jitter, extremes, fully random.
   task automatic load_setting(int kind);
      logic [31:0] base [CAL_REGS];
      logic [31:0] v;
      base[0] = {16'd26435, 16'd27504};
      base[1] = {16'd36477, 16'hFC18};
      base[2] = {16'd3024, 16'hD643};
      base[3] = {16'd140, 16'd2855};
      base[4] = {16'd15500, 16'hFFF9};
      base[5] = {16'd6000, 16'hC6F8};
      for (int i = 0; i < CAL_REGS; i++) begin
         case (kind)
            0: v = jitter(base[i]);
            1: v = 32'hFFFF_FFFF;
            2: v = 32'h7FFF_7FFF;
            3: v = 32'h8000_8000;
            4: v = 32'h0000_0000;
            default: v = $urandom;
         endcase
         csr_write(bsc_reg_type'(i), v);
      end
   endtask

   function automatic logic [19:0] raw_value(logic [19:0] centre);
      if ($urandom_range(3) == 0) return 20'($urandom);
      return centre + 20'($urandom_range(65535)) - 20'd32768;
   endfunction

   row_type rows [] = '{
      '{0, 20'h00000, 20'h00000, 1, '{16'sd0, 32'd0, 1'b0}},
      '{0, 20'hFFFFF, 20'hFFFFF, 1, '{16'sd0, 32'd0, 1'b0}},
      '{0, 20'hFFFFF, 20'h00000, 1, '{16'sd0, 32'd0, 1'b0}},
      '{0, 20'h00000, 20'hFFFFF, 1, '{16'sd0, 32'd0, 1'b0}},
      '{0, 20'h55555, 20'hAAAAA, 1, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'd519888, 20'd415148, 0, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'h00000, 20'h00000, 0, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'hFFFFF, 20'hFFFFF, 0, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'hFFFFF, 20'h00000, 0, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'h00000, 20'hFFFFF, 0, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'd440064, 20'd415148, 0, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'd519888, 20'd300000, 0, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'd519888, 20'd600000, 0, '{16'sd0, 32'd0, 1'b0}},
      '{1, 20'hAAAAA, 20'h55555, 0, '{16'sd0, 32'd0, 1'b0}}
   };

   initial begin
      sample_type got;
      int         bank;
      int         idle_pct;
      for (int i = 0; i < CAL_REGS; i++) cal_shadow[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: rows with fixed expectations are also cross-checked
      // against the predictor, so a wrong prediction shows up as well.
      bank = 0;
      foreach (rows[i]) begin
         if (rows[i].bank != bank) begin
            drain();
            load_typical();
            bank = rows[i].bank;
         end
         if (rows[i].fixed) begin
            got = compensate(rows[i].raw_t, rows[i].raw_p);
            if (got.temp !== rows[i].want.temp || got.pres !== rows[i].want.pres ||
                got.pvalid !== rows[i].want.pvalid) begin
               $error("predictor disagrees with fixed row %0d", i);
               mismatch_count++;
            end
         end
         send_sample(rows[i].raw_t, rows[i].raw_p, 0);
      end
      drain();

      // Random part: eleven calibration settings, alternating sender idling.
      for (int s = 0; s < 11; s++) begin
         load_setting(s < 6 ? (s == 0 ? 0 : (s < 5 ? s : 5)) : (s % 2 == 0 ? 0 : 5));
         idle_pct = (s % 4 == 1) ? 73 : ((s % 4 == 3) ? 9 : 0);
         for (int n = 0; n < 100; n++) begin
            if (n == 50 && s == 2) drain();
            send_sample(raw_value(20'd519888), raw_value(20'd415148), idle_pct);
         end
         drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("baro_sensor_compensation test passed");
      end else begin
         $display("baro_sensor_compensation test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
